### sv/sqtm_pkg.sv
// Shared constants, types and sequencer codes for the squarified treemap layout block.
package sqtm_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int SIZE_BITS = 40;
    localparam int FRAC_BITS = 16;
    localparam int TAG_BITS  = 16;
    localparam int CFG_BITS  = 12;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int TOTAL_W   = SIZE_BITS + IDX_W;
    localparam int FX_W      = 64;
    localparam int CELL_W    = 32;

    localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;
    localparam logic [FX_W-1:0] INF_FX = '1;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_AREA_WIDTH,
        CFG_AREA_HEIGHT
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_AREA_RD,
        ST_AREA_CALL,
        ST_AREA_WR,
        ST_ROW_TOP,
        ST_LONE_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_W_BEGIN,
        ST_W_LEN,
        ST_W_S,
        ST_W_R1,
        ST_W_R2,
        ST_W_RAT,
        ST_W_DONE,
        ST_ROW_END,
        ST_THICK,
        ST_CELL_RD,
        ST_CELL_CHK,
        ST_CELL_EXT,
        ST_FINISH,
        ST_MD_WAIT
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic            start;
        logic [FX_W-1:0] a;
        logic [FX_W-1:0] b;
        logic [FX_W-1:0] c;
    } md_req_t;

    typedef struct packed {
        logic            done;
        logic            busy;
        logic [FX_W-1:0] q;
    } md_rsp_t;

endpackage

### sv/sqtm_muldiv.sv
// Shared multiply-then-divide unit: floor(a*b/c), saturating, one bit per cycle.
module sqtm_muldiv
    import sqtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    md_state_t           state_reg, state_next;
    logic [2*FX_W-1:0]   acc_reg, acc_next;
    logic [2*FX_W-1:0]   ash_reg, ash_next;
    logic [FX_W-1:0]     bsh_reg, bsh_next;
    logic [FX_W-1:0]     c_reg, c_next;
    logic [FX_W-1:0]     rem_reg, rem_next;
    logic [FX_W-1:0]     lo_reg, lo_next;
    logic [FX_W-1:0]     q_reg, q_next;
    logic [$clog2(FX_W)-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [FX_W:0]       remsh;
    logic                fits;

    assign remsh = {rem_reg, lo_reg[FX_W-1]};
    assign fits  = remsh >= {1'b0, c_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL:  if (bsh_reg == '0) state_next = MD_CHK;
            MD_CHK:
            begin
                if (c_reg == '0 || acc_reg[2*FX_W-1:FX_W] >= c_reg)
                    state_next = MD_IDLE;
                else
                    state_next = MD_DIV;
            end
            MD_DIV:  if (cnt_reg == '1) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        ash_next  = ash_reg;
        bsh_next  = bsh_reg;
        c_next    = c_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    acc_next = '0;
                    ash_next = {{FX_W{1'b0}}, req.a};
                    bsh_next = req.b;
                    c_next   = req.c;
                end
            end
            MD_MUL:
            begin
                if (bsh_reg != '0)
                begin
                    if (bsh_reg[0])
                        acc_next = acc_reg + ash_reg;
                    ash_next = ash_reg << 1;
                    bsh_next = bsh_reg >> 1;
                end
            end
            MD_CHK:
            begin
                if (c_reg == '0 || acc_reg[2*FX_W-1:FX_W] >= c_reg)
                begin
                    q_next    = INF_FX;
                    done_next = 1'b1;
                end
                else
                begin
                    rem_next = acc_reg[2*FX_W-1:FX_W];
                    lo_next  = acc_reg[FX_W-1:0];
                    cnt_next = '0;
                end
            end
            MD_DIV:
            begin
                rem_next = fits ? FX_W'(remsh - {1'b0, c_reg}) : remsh[FX_W-1:0];
                lo_next  = lo_reg << 1;
                q_next   = {q_reg[FX_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        bsh_reg <= bsh_next;
        c_reg   <= c_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = state_reg != MD_IDLE;
    assign rsp.q    = q_reg;

endmodule

### sv/squarified_treemap_layout.sv
// Loading: the block accepts items back to back until tlast.
// Layout: every fixed-point step runs on one shared multiply-divide unit (shift-add multiply,
// check, restoring division, handoff), and the same unit scales each item's area.
// An item needs 1 to about 16 such steps; cells leave through a pending register and then
// one output register. Reset clears the sequencer, item count, total, pending valid and
// output valid; configuration resets to 392 by 252 at (4, 4); stores not cleared.
module squarified_treemap_layout
    import sqtm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_BITS-1:0]        cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [55:0]                s_tdata,   // item_size[39:0], item_tag[55:40]
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [143:0]               m_tdata,   // cell_x, cell_y, cell_w, cell_h, cell_tag
    output logic                       m_tlast,
    output logic                       m_tuser    // layout_empty
);

    logic [CFG_BITS-1:0] org_x_reg, org_y_reg, aw_reg, ah_reg;

    seq_state_t         state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next, start_reg, start_next, j_reg, j_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [FX_W-1:0]    full_reg, full_next;
    logic [FX_W-1:0]    x_reg, x_next, y_reg, y_next, w_reg, w_next, h_reg, h_next;
    logic [FX_W-1:0]    sum_reg, sum_next, amax_reg, amax_next, amin_reg, amin_next;
    logic [FX_W-1:0]    a_reg, a_next, nmax_reg, nmax_next, nmin_reg, nmin_next;
    logic [FX_W-1:0]    len_reg, len_next, s_reg, s_next, r1_reg, r1_next;
    logic [FX_W-1:0]    ratio_reg, ratio_next, w1_reg, w1_next;
    logic [FX_W-1:0]    wres_reg, wres_next, cur_reg, cur_next;
    logic [FX_W-1:0]    thick_reg, thick_next, pos_reg, pos_next;
    logic               phase_reg, phase_next, wcall_reg, wcall_next;
    logic               row_any_reg, row_any_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [CELL_W-1:0]  pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic [CELL_W-1:0]  pend_w_reg, pend_w_next, pend_h_reg, pend_h_next;
    logic [TAG_BITS-1:0] pend_tag_reg, pend_tag_next;

    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [CELL_W-1:0]  out_w_reg, out_w_next, out_h_reg, out_h_next;
    logic [TAG_BITS-1:0] out_tag_reg, out_tag_next;
    logic               out_last_reg, out_last_next, out_empty_reg, out_empty_next;

    logic [SIZE_BITS-1:0] size_mem [MAX_ITEMS];
    logic [TAG_BITS-1:0]  tag_mem  [MAX_ITEMS];
    logic [FX_W-1:0]      area_mem [MAX_ITEMS];
    logic [SIZE_BITS-1:0] size_rd;
    logic [TAG_BITS-1:0]  tag_rd;
    logic [FX_W-1:0]      area_rd;
    logic                 rd_en, load_we, area_we;
    logic [IDX_W-1:0]     rd_addr;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic [SIZE_BITS-1:0] in_size;
    logic [TAG_BITS-1:0]  in_tag;
    logic                 in_acc, in_store;
    logic [CNT_W-1:0]     in_cnt;
    logic [TOTAL_W-1:0]   in_total;
    logic [FX_W-1:0]      side, wsum, wmax, wmin;
    logic                 horiz, put_stall, fin_stall, row_go, lone;
    logic [2*CFG_BITS-1:0] area_px;

    sqtm_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == ST_LOAD;
    assign in_size   = s_tdata[SIZE_BITS-1:0];
    assign in_tag    = s_tdata[SIZE_BITS+TAG_BITS-1:SIZE_BITS];
    assign in_acc    = s_tvalid && s_tready;
    assign in_store  = in_size != '0 && cnt_reg < CNT_W'(MAX_ITEMS);
    assign in_cnt    = in_store ? cnt_reg + 1'b1 : cnt_reg;
    assign in_total  = in_store ? total_reg + TOTAL_W'(in_size) : total_reg;
    assign area_px   = {{CFG_BITS{1'b0}}, aw_reg} * {{CFG_BITS{1'b0}}, ah_reg};

    assign side      = (w_reg < h_reg) ? w_reg : h_reg;
    assign horiz     = w_reg >= h_reg;
    assign wsum      = wcall_reg ? sum_reg + a_reg : sum_reg;
    assign wmax      = wcall_reg ? nmax_reg : amax_reg;
    assign wmin      = wcall_reg ? nmin_reg : amin_reg;
    assign put_stall = pend_valid_reg && out_valid_reg && !m_tready;
    assign fin_stall = out_valid_reg && !m_tready;
    assign row_go    = start_reg < n_reg && w_reg != '0 && h_reg != '0;
    assign lone      = start_reg + 1'b1 == n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= CFG_BITS'(4);
            org_y_reg <= CFG_BITS'(4);
            aw_reg    <= CFG_BITS'(392);
            ah_reg    <= CFG_BITS'(252);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:    org_x_reg <= cfg_data;
                CFG_ORIGIN_Y:    org_y_reg <= cfg_data;
                CFG_AREA_WIDTH:  aw_reg    <= cfg_data;
                CFG_AREA_HEIGHT: ah_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_tlast)
                    state_next = (in_cnt != '0 && in_total != '0) ? ST_AREA_RD : ST_FINISH;
            end
            ST_AREA_RD:   state_next = ST_AREA_CALL;
            ST_AREA_CALL: state_next = ST_MD_WAIT;
            ST_AREA_WR:   state_next = (i_reg + 1'b1 == n_reg) ? ST_ROW_TOP : ST_AREA_RD;
            ST_ROW_TOP:
            begin
                if (!row_go)
                    state_next = ST_FINISH;
                else if (lone)
                    state_next = ST_LONE_CHK;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_LONE_CHK:  if (!(area_rd != '0 && put_stall)) state_next = ST_FINISH;
            ST_SCAN_RD:   state_next = (i_reg >= n_reg) ? ST_ROW_END : ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (area_rd == '0 || !row_any_reg)
                    state_next = ST_SCAN_RD;
                else
                    state_next = ST_W_BEGIN;
            end
            ST_W_BEGIN:
                state_next = (side == '0 || wsum == '0) ? ST_W_DONE : ST_MD_WAIT;
            ST_W_LEN:     state_next = (md_rsp.q == '0) ? ST_W_DONE : ST_MD_WAIT;
            ST_W_S:       state_next = (md_rsp.q == '0) ? ST_W_RAT : ST_MD_WAIT;
            ST_W_R1:      state_next = ST_MD_WAIT;
            ST_W_R2:      state_next = ST_W_RAT;
            ST_W_RAT:     state_next = phase_reg ? ST_W_DONE : ST_MD_WAIT;
            ST_W_DONE:
            begin
                if (!wcall_reg)
                    state_next = ST_W_BEGIN;
                else
                    state_next = (wres_reg <= cur_reg) ? ST_SCAN_RD : ST_ROW_END;
            end
            ST_ROW_END:   state_next = row_any_reg ? ST_MD_WAIT : ST_ROW_TOP;
            ST_THICK:     state_next = (md_rsp.q != '0) ? ST_CELL_RD : ST_ROW_TOP;
            ST_CELL_RD:   state_next = (j_reg >= i_reg) ? ST_ROW_TOP : ST_CELL_CHK;
            ST_CELL_CHK:  state_next = (area_rd == '0) ? ST_CELL_RD : ST_MD_WAIT;
            ST_CELL_EXT:  if (!put_stall) state_next = ST_CELL_RD;
            ST_FINISH:    if (!fin_stall) state_next = ST_LOAD;
            ST_MD_WAIT:   if (md_rsp.done) state_next = ret_reg;
            default:      state_next = ST_LOAD;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        ret_next        = ret_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        start_next      = start_reg;
        j_next          = j_reg;
        total_next      = total_reg;
        full_next       = full_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        sum_next        = sum_reg;
        amax_next       = amax_reg;
        amin_next       = amin_reg;
        a_next          = a_reg;
        nmax_next       = nmax_reg;
        nmin_next       = nmin_reg;
        len_next        = len_reg;
        s_next          = s_reg;
        r1_next         = r1_reg;
        ratio_next      = ratio_reg;
        w1_next         = w1_reg;
        wres_next       = wres_reg;
        cur_next        = cur_reg;
        thick_next      = thick_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        wcall_next      = wcall_reg;
        row_any_next    = row_any_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_w_next     = pend_w_reg;
        pend_h_next     = pend_h_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_w_next      = out_w_reg;
        out_h_next      = out_h_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        load_we         = 1'b0;
        area_we         = 1'b0;
        md_req          = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    load_we    = in_store;
                    cnt_next   = in_cnt;
                    total_next = in_total;
                    if (s_tlast)
                    begin
                        n_next         = in_cnt;
                        i_next         = '0;
                        full_next      = FX_W'(area_px) << FRAC_BITS;
                        x_next         = FX_W'(org_x_reg) << FRAC_BITS;
                        y_next         = FX_W'(org_y_reg) << FRAC_BITS;
                        w_next         = FX_W'(aw_reg) << FRAC_BITS;
                        h_next         = FX_W'(ah_reg) << FRAC_BITS;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_AREA_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg[IDX_W-1:0];
            end
            ST_AREA_CALL:
            begin
                md_req.start = 1'b1;
                md_req.a     = FX_W'(size_rd);
                md_req.b     = full_reg;
                md_req.c     = FX_W'(total_reg);
                ret_next     = ST_AREA_WR;
            end
            ST_AREA_WR:
            begin
                area_we = 1'b1;
                i_next  = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                    start_next = '0;
            end
            ST_ROW_TOP:
            begin
                if (row_go)
                begin
                    if (lone)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = start_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        row_any_next = 1'b0;
                        i_next       = start_reg;
                    end
                end
            end
            ST_LONE_CHK:
            begin
                // the last item fills the whole remaining rectangle
                if (area_rd != '0 && !put_stall)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next     = pend_x_reg;
                        out_y_next     = pend_y_reg;
                        out_w_next     = pend_w_reg;
                        out_h_next     = pend_h_reg;
                        out_tag_next   = pend_tag_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = x_reg[CELL_W-1:0];
                    pend_y_next     = y_reg[CELL_W-1:0];
                    pend_w_next     = w_reg[CELL_W-1:0];
                    pend_h_next     = h_reg[CELL_W-1:0];
                    pend_tag_next   = tag_rd;
                end
            end
            ST_SCAN_RD:
            begin
                if (i_reg < n_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = i_reg[IDX_W-1:0];
                end
            end
            ST_SCAN_CHK:
            begin
                if (area_rd == '0)
                    i_next = i_reg + 1'b1;
                else if (!row_any_reg)
                begin
                    row_any_next = 1'b1;
                    sum_next     = area_rd;
                    amax_next    = area_rd;
                    amin_next    = area_rd;
                    i_next       = i_reg + 1'b1;
                end
                else
                begin
                    a_next     = area_rd;
                    nmax_next  = (area_rd > amax_reg) ? area_rd : amax_reg;
                    nmin_next  = (area_rd < amin_reg) ? area_rd : amin_reg;
                    wcall_next = 1'b0;
                end
            end
            ST_W_BEGIN:
            begin
                if (side == '0 || wsum == '0)
                    wres_next = INF_FX;
                else
                begin
                    md_req.start = 1'b1;
                    md_req.a     = wsum;
                    md_req.b     = ONE_FX;
                    md_req.c     = side;
                    ret_next     = ST_W_LEN;
                end
            end
            ST_W_LEN:
            begin
                if (md_rsp.q == '0)
                    wres_next = INF_FX;
                else
                begin
                    len_next     = md_rsp.q;
                    phase_next   = 1'b0;
                    md_req.start = 1'b1;
                    md_req.a     = wmax;
                    md_req.b     = ONE_FX;
                    md_req.c     = md_rsp.q;
                    ret_next     = ST_W_S;
                end
            end
            ST_W_S:
            begin
                if (md_rsp.q == '0)
                    ratio_next = INF_FX;
                else
                begin
                    s_next       = md_rsp.q;
                    md_req.start = 1'b1;
                    md_req.a     = md_rsp.q;
                    md_req.b     = ONE_FX;
                    md_req.c     = len_reg;
                    ret_next     = ST_W_R1;
                end
            end
            ST_W_R1:
            begin
                r1_next      = md_rsp.q;
                md_req.start = 1'b1;
                md_req.a     = len_reg;
                md_req.b     = ONE_FX;
                md_req.c     = s_reg;
                ret_next     = ST_W_R2;
            end
            ST_W_R2:
                ratio_next = (r1_reg > md_rsp.q) ? r1_reg : md_rsp.q;
            ST_W_RAT:
            begin
                if (!phase_reg)
                begin
                    w1_next      = ratio_reg;
                    phase_next   = 1'b1;
                    md_req.start = 1'b1;
                    md_req.a     = wmin;
                    md_req.b     = ONE_FX;
                    md_req.c     = len_reg;
                    ret_next     = ST_W_S;
                end
                else
                    wres_next = (w1_reg > ratio_reg) ? w1_reg : ratio_reg;
            end
            ST_W_DONE:
            begin
                if (!wcall_reg)
                begin
                    cur_next   = wres_reg;
                    wcall_next = 1'b1;
                end
                else if (wres_reg <= cur_reg)
                begin
                    sum_next  = sum_reg + a_reg;
                    amax_next = nmax_reg;
                    amin_next = nmin_reg;
                    i_next    = i_reg + 1'b1;
                end
            end
            ST_ROW_END:
            begin
                if (!row_any_reg)
                    start_next = start_reg + 1'b1;
                else
                begin
                    md_req.start = 1'b1;
                    md_req.a     = sum_reg;
                    md_req.b     = ONE_FX;
                    md_req.c     = horiz ? w_reg : h_reg;
                    ret_next     = ST_THICK;
                end
            end
            ST_THICK:
            begin
                thick_next = md_rsp.q;
                if (md_rsp.q != '0)
                begin
                    pos_next = horiz ? x_reg : y_reg;
                    j_next   = start_reg;
                end
                else
                    start_next = i_reg;
            end
            ST_CELL_RD:
            begin
                if (j_reg >= i_reg)
                begin
                    // shrink the rectangle by the finished row
                    if (horiz)
                    begin
                        y_next = y_reg + thick_reg;
                        h_next = (h_reg > thick_reg) ? h_reg - thick_reg : '0;
                    end
                    else
                    begin
                        x_next = x_reg + thick_reg;
                        w_next = (w_reg > thick_reg) ? w_reg - thick_reg : '0;
                    end
                    start_next = i_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg[IDX_W-1:0];
                end
            end
            ST_CELL_CHK:
            begin
                if (area_rd == '0)
                    j_next = j_reg + 1'b1;
                else
                begin
                    md_req.start = 1'b1;
                    md_req.a     = area_rd;
                    md_req.b     = ONE_FX;
                    md_req.c     = thick_reg;
                    ret_next     = ST_CELL_EXT;
                end
            end
            ST_CELL_EXT:
            begin
                if (!put_stall)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next     = pend_x_reg;
                        out_y_next     = pend_y_reg;
                        out_w_next     = pend_w_reg;
                        out_h_next     = pend_h_reg;
                        out_tag_next   = pend_tag_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = horiz ? pos_reg[CELL_W-1:0] : x_reg[CELL_W-1:0];
                    pend_y_next     = horiz ? y_reg[CELL_W-1:0] : pos_reg[CELL_W-1:0];
                    pend_w_next     = horiz ? md_rsp.q[CELL_W-1:0] : thick_reg[CELL_W-1:0];
                    pend_h_next     = horiz ? thick_reg[CELL_W-1:0] : md_rsp.q[CELL_W-1:0];
                    pend_tag_next   = tag_rd;
                    pos_next        = pos_reg + md_rsp.q;
                    j_next          = j_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!fin_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = pend_valid_reg ? pend_x_reg : '0;
                    out_y_next      = pend_valid_reg ? pend_y_reg : '0;
                    out_w_next      = pend_valid_reg ? pend_w_reg : '0;
                    out_h_next      = pend_valid_reg ? pend_h_reg : '0;
                    out_tag_next    = pend_valid_reg ? pend_tag_reg : '0;
                    out_last_next   = pend_valid_reg;
                    out_empty_next  = !pend_valid_reg;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    total_next      = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            ret_reg        <= ST_LOAD;
            cnt_reg        <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        start_reg   <= start_next;
        j_reg       <= j_next;
        full_reg    <= full_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        sum_reg     <= sum_next;
        amax_reg    <= amax_next;
        amin_reg    <= amin_next;
        a_reg       <= a_next;
        nmax_reg    <= nmax_next;
        nmin_reg    <= nmin_next;
        len_reg     <= len_next;
        s_reg       <= s_next;
        r1_reg      <= r1_next;
        ratio_reg   <= ratio_next;
        w1_reg      <= w1_next;
        wres_reg    <= wres_next;
        cur_reg     <= cur_next;
        thick_reg   <= thick_next;
        pos_reg     <= pos_next;
        phase_reg   <= phase_next;
        wcall_reg   <= wcall_next;
        row_any_reg <= row_any_next;
        pend_x_reg  <= pend_x_next;
        pend_y_reg  <= pend_y_next;
        pend_w_reg  <= pend_w_next;
        pend_h_reg  <= pend_h_next;
        pend_tag_reg <= pend_tag_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_w_reg   <= out_w_next;
        out_h_reg   <= out_h_next;
        out_tag_reg <= out_tag_next;
        out_last_reg <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            size_mem[cnt_reg[IDX_W-1:0]] <= in_size;
            tag_mem[cnt_reg[IDX_W-1:0]]  <= in_tag;
        end
        if (area_we)
            area_mem[i_reg[IDX_W-1:0]] <= md_rsp.q;
        if (rd_en)
        begin
            size_rd <= size_mem[rd_addr];
            tag_rd  <= tag_mem[rd_addr];
            area_rd <= area_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tag_reg, out_h_reg, out_w_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

`ifndef SYNTHESIS
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (!m_tlast && m_tdata == '0))
        else $error("empty layout result carries cell data");

    a_md_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("divide unit started while busy");

    a_load_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !pend_valid_reg)
        else $error("pending cell left over after layout");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the squarified treemap layout block.
`timescale 1ns / 1ps

module testbench
    import sqtm_pkg::*;
();

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] tag;
        logic        last;
        logic        empty;
    } cell_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    cfg_reg_t     cfg_index;
    logic [11:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    // predictor state
    logic [63:0]  org_x, org_y, rect_w, rect_h;
    logic [63:0]  stored_size [MAX_ITEMS];
    logic [15:0]  stored_tag [MAX_ITEMS];
    int           stored_count;
    logic [63:0]  stored_total;

    cell_t        pending_cells [$];
    int           error_count;
    int           burst_left;
    int           cells_seen;

    squarified_treemap_layout DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        if (c == 0 || p[127:64] >= c)
            return '1;
        q = p / {64'd0, c};
        return q[63:0];
    endfunction

    function automatic logic [63:0] aspect(logic [63:0] a, logic [63:0] len);
        logic [63:0] s, r1, r2;
        s = mul_div(a, ONE_FX, len);
        if (s == 0)
            return '1;
        r1 = mul_div(s, ONE_FX, len);
        r2 = mul_div(len, ONE_FX, s);
        return (r1 > r2) ? r1 : r2;
    endfunction

    function automatic logic [63:0] row_worst(logic [63:0] sum, logic [63:0] amax,
                                             logic [63:0] amin, logic [63:0] side);
        logic [63:0] len, w1, w2;
        if (side == 0 || sum == 0)
            return '1;
        len = mul_div(sum, ONE_FX, side);
        if (len == 0)
            return '1;
        w1 = aspect(amax, len);
        w2 = aspect(amin, len);
        return (w1 > w2) ? w1 : w2;
    endfunction

    function automatic void add_cell(logic [63:0] x, logic [63:0] y, logic [63:0] w,
                                     logic [63:0] h, logic [15:0] tag);
        cell_t c;
        c.x = x[31:0];
        c.y = y[31:0];
        c.w = w[31:0];
        c.h = h[31:0];
        c.tag = tag;
        c.last = 1'b0;
        c.empty = 1'b0;
        pending_cells.insert(pending_cells.size(), c);
    endfunction

    // Build the expected cells of one layout and queue them.
    function automatic void predict_layout();
        logic [63:0] area [MAX_ITEMS];
        int          row_idx [MAX_ITEMS];
        logic [63:0] x, y, w, h, full, side, sum, amax, amin, thick, pos, ext, a;
        logic [63:0] nmax, nmin;
        int          n, first, i, j, rn, placed;
        logic        horiz, grow;
        cell_t       c;
        n = stored_count;
        first = 0;
        placed = 0;
        x = org_x << FRAC_BITS;
        y = org_y << FRAC_BITS;
        w = rect_w << FRAC_BITS;
        h = rect_h << FRAC_BITS;
        full = (rect_w * rect_h) << FRAC_BITS;
        if (n > 0 && stored_total > 0)
        begin
            for (i = 0; i < n; i++)
                area[i] = mul_div(stored_size[i], full, stored_total);
            while (first < n && w > 0 && h > 0)
            begin
                if (n - first == 1)
                begin
                    if (area[first] > 0)
                    begin
                        add_cell(x, y, w, h, stored_tag[first]);
                        placed++;
                    end
                    break;
                end
                side = (w < h) ? w : h;
                horiz = (w >= h);
                rn = 0;
                sum = 0;
                amax = 0;
                amin = 0;
                i = first;
                grow = 1'b1;
                while (i < n && grow)
                begin
                    a = area[i];
                    if (a == 0)
                        i++;
                    else if (rn == 0)
                    begin
                        row_idx[rn++] = i;
                        sum = a;
                        amax = a;
                        amin = a;
                        i++;
                    end
                    else
                    begin
                        nmax = (a > amax) ? a : amax;
                        nmin = (a < amin) ? a : amin;
                        if (row_worst(sum + a, nmax, nmin, side)
                            <= row_worst(sum, amax, amin, side))
                        begin
                            row_idx[rn++] = i;
                            sum += a;
                            amax = nmax;
                            amin = nmin;
                            i++;
                        end
                        else
                            grow = 1'b0;
                    end
                end
                if (rn == 0)
                begin
                    first++;
                    continue;
                end
                thick = mul_div(sum, ONE_FX, horiz ? w : h);
                if (thick != 0)
                begin
                    pos = horiz ? x : y;
                    for (j = 0; j < rn; j++)
                    begin
                        ext = mul_div(area[row_idx[j]], ONE_FX, thick);
                        if (horiz)
                            add_cell(pos, y, ext, thick, stored_tag[row_idx[j]]);
                        else
                            add_cell(x, pos, thick, ext, stored_tag[row_idx[j]]);
                        placed++;
                        pos += ext;
                    end
                    if (horiz)
                    begin
                        y += thick;
                        h = (h > thick) ? h - thick : '0;
                    end
                    else
                    begin
                        x += thick;
                        w = (w > thick) ? w - thick : '0;
                    end
                end
                first = i;
            end
        end
        if (placed == 0)
        begin
            c = '0;
            c.empty = 1'b1;
            pending_cells.insert(pending_cells.size(), c);
        end
        else
            pending_cells[pending_cells.size() - 1].last = 1'b1;
        stored_count = 0;
        stored_total = 0;
    endfunction

    function automatic void predict_item(logic [39:0] size, logic [15:0] tag, logic last);
        if (size != 0 && stored_count < MAX_ITEMS)
        begin
            stored_size[stored_count] = {24'd0, size};
            stored_tag[stored_count] = tag;
            stored_count++;
            stored_total += {24'd0, size};
        end
        if (last)
            predict_layout();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one item; tvalid stays high inside a burst and drops for the gaps.
    task automatic send_item(logic [39:0] size, logic [15:0] tag, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {tag, size};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(size, tag, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ORIGIN_X:    org_x = {52'd0, value};
            CFG_ORIGIN_Y:    org_y = {52'd0, value};
            CFG_AREA_WIDTH:  rect_w = {52'd0, value};
            default:         rect_h = {52'd0, value};
        endcase
    endtask

    task automatic set_rect(logic [11:0] ox, logic [11:0] oy, logic [11:0] w,
                            logic [11:0] h);
        wait_drained();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_AREA_WIDTH, w);
        write_reg(CFG_AREA_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [39:0] rand_size();
        logic [39:0] s;
        s = 40'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: s = s >> $urandom_range(0, 39);
            1: s = s & 40'hFFFF;
            default: ;
        endcase
        return s;
    endfunction

    task automatic test_directed();
        // one item filling the whole rectangle, extremes of tag
        send_item(40'hFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(40'd1, 16'h0000, 1'b1);
        // empty layouts: lone zero item, zeros only
        send_item(40'd0, 16'h1234, 1'b1);
        send_item(40'd0, 16'h1, 1'b0);
        send_item(40'd0, 16'h2, 1'b1);
        // classic descending set with a skipped zero in the middle
        send_item(40'd6, 16'hA001, 1'b0);
        send_item(40'd6, 16'hA002, 1'b0);
        send_item(40'd4, 16'hA003, 1'b0);
        send_item(40'd0, 16'hA004, 1'b0);
        send_item(40'd3, 16'hA005, 1'b0);
        send_item(40'd2, 16'hA006, 1'b0);
        send_item(40'd2, 16'hA007, 1'b0);
        send_item(40'd1, 16'hA008, 1'b1);
        // tiny item next to a huge one truncates to zero area
        send_item(40'hFF_FFFF_FFFF, 16'hB001, 1'b0);
        send_item(40'd1, 16'hB002, 1'b1);
        // zero item carrying last after real ones
        send_item(40'd500, 16'hC001, 1'b0);
        send_item(40'd0, 16'hC002, 1'b1);
    endtask

    task automatic test_full_store();
        int i;
        // overflow the store; extra items are dropped
        for (i = 0; i < MAX_ITEMS + 4; i++)
            send_item(40'(1000 - i), i[15:0], i == MAX_ITEMS + 3);
    endtask

    task automatic test_random_layouts(int items);
        int sent, n, i;
        logic [39:0] base;
        sent = 0;
        while (sent < items)
        begin
            n = $urandom_range(1, 12);
            base = rand_size();
            for (i = 0; i < n; i++)
            begin
                // mostly descending, sometimes noise
                if ($urandom_range(0, 4) == 0)
                    send_item(rand_size(), 16'($urandom), i == n - 1);
                else
                begin
                    send_item(base, 16'($urandom), i == n - 1);
                    base = base - (base >> $urandom_range(0, 4));
                end
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    task automatic test_settings();
        set_rect(12'd0, 12'd0, 12'd1, 12'd1);
        test_random_layouts(15);
        set_rect(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        test_random_layouts(25);
        set_rect(12'd10, 12'd20, 12'd1, 12'hFFF);
        test_random_layouts(15);
        set_rect(12'd7, 12'd3, 12'hFFF, 12'd2);
        test_random_layouts(15);
        set_rect(12'($urandom), 12'($urandom), 12'($urandom_range(1, 4095)),
                 12'($urandom_range(1, 4095)));
        test_random_layouts(30);
        set_rect(12'd4, 12'd4, 12'd392, 12'd252);
        test_random_layouts(60);
    endtask

    // result checker with its own stall pattern
    always @(posedge clk)
    begin
        cell_t got, want;
        if (m_tvalid && m_tready)
        begin
            got.x = m_tdata[31:0];
            got.y = m_tdata[63:32];
            got.w = m_tdata[95:64];
            got.h = m_tdata[127:96];
            got.tag = m_tdata[143:128];
            got.last = m_tlast;
            got.empty = m_tuser;
            cells_seen++;
            if (pending_cells.size() == 0)
                report_mismatch("unexpected cell", 64'(got.tag), 64'd0);
            else
            begin
                want = pending_cells.pop_front();
                if (got.x != want.x) report_mismatch("cell_x", 64'(got.x), 64'(want.x));
                if (got.y != want.y) report_mismatch("cell_y", 64'(got.y), 64'(want.y));
                if (got.w != want.w) report_mismatch("cell_w", 64'(got.w), 64'(want.w));
                if (got.h != want.h) report_mismatch("cell_h", 64'(got.h), 64'(want.h));
                if (got.tag != want.tag)
                    report_mismatch("cell_tag", 64'(got.tag), 64'(want.tag));
                if (got.last != want.last)
                    report_mismatch("cell_last", 64'(got.last), 64'(want.last));
                if (got.empty != want.empty)
                    report_mismatch("layout_empty", 64'(got.empty), 64'(want.empty));
            end
        end
        if (rst_n)
            m_tready <= ((cells_seen / 40) % 3 == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        error_count = 0;
        burst_left = 0;
        cells_seen = 0;
        org_x = 4;
        org_y = 4;
        rect_w = 392;
        rect_h = 252;
        stored_count = 0;
        stored_total = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_settings();
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
